/* design/icst_pkg.sv */
`default_nettype none
package icst_pkg;

    localparam int RANK_W  = 11;
    localparam int NODE_W  = 20;
    localparam int TOTAL_W = 40;
    localparam int APB_W   = 32;

    localparam logic [NODE_W-1:0]  NODE_MAX  = {NODE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [RANK_W-1:0] KEY_COUNT_RESET = 11'd1024;

    // port enables of the node store
    typedef struct packed {
        logic rd_a_en;
        logic rd_b_en;
        logic wr_en;
    } t_mem_ctl;

endpackage
`default_nettype wire

/* design/inversion_counter_segment_tree.sv */
`default_nettype none
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------------
// in       | to block  | i_in_valid / o_in_ready    | i_rank
// out      | from block| o_out_valid / i_out_ready  | o_greater_count, o_inversion_total,
//          |           |                            | o_rank_error
// cfg      | to block  | APB psel/penable/pwrite    | paddr, pwdata, prdata (key_count)
//
// A valid rank runs from accept to result as an update walk and then a query:
// one port-A read per tree level on the update walk, then one level per cycle on the query.
// An out-of-range rank skips both walks and goes straight to the result. One item is in flight; a finished
// beat may wait in the output register while the next item is accepted and worked on.
// After reset the node store is cleared, one entry a cycle, over all 2*KEYS entries; no beat is
// accepted during that pass. A stalled output holds the walker in its final state.
module inversion_counter_segment_tree #(
    parameter int KEYS = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [icst_pkg::RANK_W-1:0]   i_rank,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [icst_pkg::NODE_W-1:0]   o_greater_count,
    output logic [icst_pkg::TOTAL_W-1:0]  o_inversion_total,
    output logic                          o_rank_error,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [1:0]                    paddr,
    input  wire  [icst_pkg::APB_W-1:0]    pwdata,
    output logic [icst_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import icst_pkg::*;

    localparam int DEPTH  = 2 * KEYS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [RANK_W-1:0]  key_count;
    t_mem_ctl           mem_ctl;
    logic [ADDR_W-1:0]  rd_a_addr;
    logic [ADDR_W-1:0]  rd_b_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [NODE_W-1:0]  wr_data;
    logic [NODE_W-1:0]  rd_a_data;
    logic [NODE_W-1:0]  rd_b_data;

    icst_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_key_count (key_count)
    );

    icst_node_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_a_data (rd_a_data),
        .o_rd_b_data (rd_b_data)
    );

    icst_walker #(
        .KEYS   (KEYS),
        .ADDR_W (ADDR_W)
    ) u_walker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_key_count       (key_count),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rank            (i_rank),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_greater_count   (o_greater_count),
        .o_inversion_total (o_inversion_total),
        .o_rank_error      (o_rank_error),
        .o_mem_ctl         (mem_ctl),
        .o_rd_a_addr       (rd_a_addr),
        .o_rd_b_addr       (rd_b_addr),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .i_rd_a_data       (rd_a_data),
        .i_rd_b_data       (rd_b_data)
    );

    // a write-back never targets the node being read on the same port
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.wr_en && mem_ctl.rd_a_en) |-> (wr_addr != rd_a_addr))
        else $error("node store read and write hit the same entry");

    // the clearing pass keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input open during clearing pass");

    // one item at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat accepted while an item is in flight");

    // a flagged rank never reports a count
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rank_error) |-> (o_greater_count == '0))
        else $error("rank error beat carries a nonzero count");

endmodule
`default_nettype wire

/* design/icst_node_mem.sv */
`default_nettype none
module icst_node_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire                          i_clk,
    input  icst_pkg::t_mem_ctl           i_ctl,
    input  wire  [ADDR_W-1:0]            i_rd_a_addr,
    input  wire  [ADDR_W-1:0]            i_rd_b_addr,
    input  wire  [ADDR_W-1:0]            i_wr_addr,
    input  wire  [icst_pkg::NODE_W-1:0]  i_wr_data,
    output logic [icst_pkg::NODE_W-1:0]  o_rd_a_data,
    output logic [icst_pkg::NODE_W-1:0]  o_rd_b_data
);
    import icst_pkg::*;

    logic [NODE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_a_en) begin
            o_rd_a_data <= r_mem[i_rd_a_addr];
        end
        if (i_ctl.rd_b_en) begin
            o_rd_b_data <= r_mem[i_rd_b_addr];
        end
    end

endmodule
`default_nettype wire

/* design/icst_apb_regs.sv */
`default_nettype none
module icst_apb_regs (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [1:0]                  paddr,
    input  wire  [icst_pkg::APB_W-1:0]  pwdata,
    output logic [icst_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output logic [icst_pkg::RANK_W-1:0] o_key_count
);
    import icst_pkg::*;

    logic [RANK_W-1:0] r_key_count;
    logic              wr_hit;

    // one register: every word address falls on key_count
    assign wr_hit = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
    assign pready = 1'b1;
    assign prdata = {{(APB_W-RANK_W){1'b0}}, r_key_count};
    assign o_key_count = r_key_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RESET;
        end else if (wr_hit) begin
            r_key_count <= pwdata[RANK_W-1:0];
        end
    end

endmodule
`default_nettype wire

/* design/icst_walker.sv */
`default_nettype none
module icst_walker #(
    parameter int KEYS   = 1024,
    parameter int ADDR_W = 11
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [icst_pkg::RANK_W-1:0]   i_key_count,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [icst_pkg::RANK_W-1:0]   i_rank,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [icst_pkg::NODE_W-1:0]   o_greater_count,
    output logic [icst_pkg::TOTAL_W-1:0]  o_inversion_total,
    output logic                          o_rank_error,
    output icst_pkg::t_mem_ctl            o_mem_ctl,
    output logic [ADDR_W-1:0]             o_rd_a_addr,
    output logic [ADDR_W-1:0]             o_rd_b_addr,
    output logic [ADDR_W-1:0]             o_wr_addr,
    output logic [icst_pkg::NODE_W-1:0]   o_wr_data,
    input  wire  [icst_pkg::NODE_W-1:0]   i_rd_a_data,
    input  wire  [icst_pkg::NODE_W-1:0]   i_rd_b_data
);
    import icst_pkg::*;

    localparam int DEPTH = 2 * KEYS;
    localparam int LW    = ADDR_W + 1;
    localparam int EW    = $clog2(KEYS + 1);
    localparam int SW    = NODE_W + 2;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_GAP  = 3'd3;
    localparam logic [2:0] ST_QRY  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_adr, n_clr_adr;
    logic [ADDR_W-1:0]   r_p, n_p;
    logic [ADDR_W-1:0]   r_wadr, n_wadr;
    logic                r_wpend, n_wpend;
    logic [LW-1:0]       r_lo, n_lo;
    logic [LW-1:0]       r_hi, n_hi;
    logic                r_pa, n_pa;
    logic                r_pb, n_pb;
    logic [NODE_W-1:0]   r_sum, n_sum;
    logic                r_err, n_err;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic [NODE_W-1:0]   r_out_gc;
    logic [TOTAL_W-1:0]  r_out_tot;
    logic                r_out_err;

    logic [EW-1:0]       eff_keys;
    logic                rank_bad;
    logic                accept;
    logic                more;
    logic                out_free;
    logic                load_out;
    logic [SW-1:0]       acc;
    logic [TOTAL_W:0]    tot_add;
    logic [TOTAL_W-1:0]  tot_sat;

    always_comb begin
        if (32'(i_key_count) > 32'(KEYS)) begin
            eff_keys = EW'(KEYS);
        end else begin
            eff_keys = EW'(i_key_count);
        end
    end

    assign rank_bad   = (i_rank == '0) || (32'(i_rank) > 32'(eff_keys));
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign more       = (r_lo < r_hi);
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = (r_state == ST_FIN) && out_free;

    // port A walks the update path, then serves the left edge of the query
    always_comb begin
        o_mem_ctl.rd_a_en = (r_state == ST_UPD) || ((r_state == ST_QRY) && more && r_lo[0]);
        o_mem_ctl.rd_b_en = (r_state == ST_QRY) && more && r_hi[0];
        o_mem_ctl.wr_en   = (r_state == ST_CLR) || r_wpend;
        o_rd_a_addr       = (r_state == ST_UPD) ? r_p : r_lo[ADDR_W-1:0];
        o_rd_b_addr       = ADDR_W'(r_hi - LW'(1));
        o_wr_addr         = (r_state == ST_CLR) ? r_clr_adr : r_wadr;
        if (r_state == ST_CLR) begin
            o_wr_data = '0;
        end else if (i_rd_a_data == NODE_MAX) begin
            o_wr_data = NODE_MAX;
        end else begin
            o_wr_data = i_rd_a_data + NODE_W'(1);
        end
    end

    always_comb begin
        acc = SW'(r_sum) + (r_pa ? SW'(i_rd_a_data) : SW'(0))
                         + (r_pb ? SW'(i_rd_b_data) : SW'(0));
        tot_add = {1'b0, r_total} + (TOTAL_W+1)'(r_sum);
        tot_sat = tot_add[TOTAL_W] ? TOTAL_MAX : tot_add[TOTAL_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_clr_adr   = r_clr_adr;
        n_p         = r_p;
        n_wadr      = r_wadr;
        n_wpend     = 1'b0;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pa        = 1'b0;
        n_pb        = 1'b0;
        n_sum       = (acc > SW'(NODE_MAX)) ? NODE_MAX : acc[NODE_W-1:0];
        n_err       = r_err;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_CLR: begin
                n_clr_adr = r_clr_adr + ADDR_W'(1);
                if (r_clr_adr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_sum = '0;
                    n_err = rank_bad;
                    n_p   = ADDR_W'(32'(KEYS) + 32'(i_rank) - 32'd1);
                    n_lo  = LW'(32'(KEYS) + 32'(i_rank));
                    n_hi  = LW'(32'(KEYS) + 32'(eff_keys));
                    n_state = rank_bad ? ST_FIN : ST_UPD;
                end
            end
            ST_UPD: begin
                // read this node now, write it back next cycle
                n_wpend = 1'b1;
                n_wadr  = r_p;
                n_p     = r_p >> 1;
                if (r_p == ADDR_W'(1)) begin
                    n_state = ST_GAP;
                end
            end
            ST_GAP: begin
                // root write lands here, query reads start after it
                n_state = ST_QRY;
            end
            ST_QRY: begin
                if (more) begin
                    n_pa = r_lo[0];
                    n_pb = r_hi[0];
                    n_lo = (r_lo + LW'(r_lo[0])) >> 1;
                    n_hi = (r_hi - LW'(r_hi[0])) >> 1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_err) begin
                        n_total = tot_sat;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_adr   <= '0;
            r_wpend     <= 1'b0;
            r_pa        <= 1'b0;
            r_pb        <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_adr   <= n_clr_adr;
            r_wpend     <= n_wpend;
            r_pa        <= n_pa;
            r_pb        <= n_pb;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_wadr <= n_wadr;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_sum  <= n_sum;
        r_err  <= n_err;
        if (load_out) begin
            r_out_gc  <= r_sum;
            r_out_tot <= r_err ? r_total : tot_sat;
            r_out_err <= r_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_greater_count   = r_out_gc;
    assign o_inversion_total = r_out_tot;
    assign o_rank_error      = r_out_err;

endmodule
`default_nettype wire

/* test/tb_inversion_counter_segment_tree.sv */
`timescale 1ns / 100ps

module tb_inversion_counter_segment_tree;
    import icst_pkg::*;

    localparam int TREE_KEYS      = 1024;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 138;

    localparam logic [1:0] KEY_COUNT_ADDR = 2'd0;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [NODE_W-1:0]  greater;
        logic [TOTAL_W-1:0] total;
        logic               err;
    } t_rank_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [RANK_W-1:0]   i_rank;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [NODE_W-1:0]   o_greater_count;
    logic [TOTAL_W-1:0]  o_inversion_total;
    logic                o_rank_error;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [1:0]          paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    bit gaps_on;
    bit stalls_on;
    int idle_cycles = 0;

    inversion_counter_segment_tree #(.KEYS(TREE_KEYS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rank           (i_rank),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_greater_count  (o_greater_count),
        .o_inversion_total(o_inversion_total),
        .o_rank_error     (o_rank_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Segment tree of rank counts, inversion total and key count, mirrored.
    class inversion_scoreboard;
        logic [NODE_W-1:0]  node_count [2*TREE_KEYS];
        logic [TOTAL_W-1:0] inv_total;
        logic [RANK_W-1:0]  key_count;
        t_rank_result       expected_q [$];
        int                 errors;

        function new();
            foreach (node_count[i]) node_count[i] = '0;
            inv_total = '0;
            key_count = KEY_COUNT_RESET;
            errors    = 0;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_key_count(logic [RANK_W-1:0] value);
            key_count = value;
        endfunction

        function void note_rank(logic [RANK_W-1:0] rank);
            t_rank_result       r;
            int unsigned        eff;
            int unsigned        p;
            int unsigned        lo;
            int unsigned        hi;
            logic [63:0]        acc;
            logic [TOTAL_W:0]   next_total;
            eff = (key_count > TREE_KEYS) ? TREE_KEYS : key_count;
            r.rank    = rank;
            r.greater = '0;
            r.err     = 1'b0;
            if (rank == 0 || rank > eff) begin
                r.err   = 1'b1;
                r.total = inv_total;
            end else begin
                p = TREE_KEYS + rank - 1;
                while (p >= 1) begin
                    if (node_count[p] != NODE_MAX) node_count[p] = node_count[p] + 1'b1;
                    p = p >> 1;
                end
                // count leaves rank+1..eff, i.e. zero-based rank..eff-1
                acc = '0;
                lo  = TREE_KEYS + rank;
                hi  = TREE_KEYS + eff;
                while (lo < hi) begin
                    if ((lo & 1) != 0) begin
                        acc = acc + node_count[lo];
                        lo  = lo + 1;
                    end
                    if ((hi & 1) != 0) begin
                        hi  = hi - 1;
                        acc = acc + node_count[hi];
                    end
                    lo = lo >> 1;
                    hi = hi >> 1;
                end
                r.greater  = (acc > NODE_MAX) ? NODE_MAX : acc[NODE_W-1:0];
                next_total = {1'b0, inv_total} + r.greater;
                inv_total  = (next_total > TOTAL_MAX) ? TOTAL_MAX : next_total[TOTAL_W-1:0];
                r.total    = inv_total;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [NODE_W-1:0] greater, logic [TOTAL_W-1:0] total,
                                   logic err);
            t_rank_result x;
            if (expected_q.size() == 0) begin
                fail($sformatf("unexpected beat greater=%0d total=%0d err=%0b",
                               greater, total, err));
                return;
            end
            x = expected_q.pop_front();
            if (greater !== x.greater || total !== x.total || err !== x.err)
                fail($sformatf("rank %0d: exp greater=%0d total=%0d err=%0b, got %0d %0d %0b",
                               x.rank, x.greater, x.total, x.err, greater, total, err));
        endfunction
    endclass

    inversion_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: retire results before noting new ranks in the same cycle.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result(o_greater_count, o_inversion_total, o_rank_error);
        if (i_in_valid && o_in_ready)
            sb.note_rank(i_rank);
        if (psel && penable && pwrite && pready && paddr == KEY_COUNT_ADDR)
            sb.set_key_count(pwdata[RANK_W-1:0]);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("inversion_counter_segment_tree regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts while enabled.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic push_rank(input logic [RANK_W-1:0] rank);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rank     <= rank;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, let the monitor note the last beat, drain all results, then go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write key_count, then read it back.
    task automatic program_key_count(input logic [RANK_W-1:0] value);
        logic [APB_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_COUNT_ADDR;
        pwdata  <= APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[RANK_W-1:0] !== value)
            sb.fail($sformatf("key_count readback exp %0d got %0d", value,
                              readback[RANK_W-1:0]));
    endtask

    function automatic logic [RANK_W-1:0] pick_rank(int unsigned keys);
        int unsigned eff;
        int unsigned roll;
        eff  = (keys > TREE_KEYS) ? TREE_KEYS : keys;
        roll = $urandom_range(0, 19);
        if (eff == 0 || roll < 2)
            return RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
        if (roll < 4)
            return (roll == 2) ? RANK_W'(1) : RANK_W'(eff);
        return RANK_W'($urandom_range(1, eff));
    endfunction

    initial begin
        logic [RANK_W-1:0] wide_ranks [12];
        logic [RANK_W-1:0] one_ranks  [4];
        logic [RANK_W-1:0] zero_ranks [2];
        logic [RANK_W-1:0] over_ranks [4];
        int unsigned       phase_keys [9];
        int unsigned       keys;

        wide_ranks = '{11'd1024, 11'd1, 11'd512, 11'd1024, 11'd0, 11'd1025, 11'd2047,
                       11'd1, 11'd513, 11'd1023, 11'd2, 11'd1024};
        one_ranks  = '{11'd1, 11'd2, 11'd0, 11'd1};
        zero_ranks = '{11'd1, 11'd1024};
        over_ranks = '{11'd1024, 11'd1025, 11'd1, 11'd2047};

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rank     <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        phase_keys  = '{1024, 3, 2047, 1, 2, 1023, 0, 1024, 700};
        phase_keys[6] = $urandom_range(4, 1022);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full range from reset, then one key, no keys, and a key count above the tree
        foreach (wide_ranks[i]) push_rank(wide_ranks[i]);
        settle();
        program_key_count(11'd1);
        foreach (one_ranks[i]) push_rank(one_ranks[i]);
        settle();
        program_key_count(11'd0);
        foreach (zero_ranks[i]) push_rank(zero_ranks[i]);
        settle();
        program_key_count(11'd2047);
        foreach (over_ranks[i]) push_rank(over_ranks[i]);

        foreach (phase_keys[ph]) begin
            settle();
            keys = phase_keys[ph];
            if (ph == 8) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            program_key_count(RANK_W'(keys));
            repeat (PHASE_ITEMS) push_rank(pick_rank(keys));
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("inversion_counter_segment_tree regression: pass");
        else
            $display("inversion_counter_segment_tree regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/icst_pkg.sv
design/icst_node_mem.sv
design/icst_apb_regs.sv
design/icst_walker.sv
design/inversion_counter_segment_tree.sv
test/tb_inversion_counter_segment_tree.sv
